>>> rtl/dcip_pkg.sv
package dcip_pkg;

    // Parse phases, one per region of the file
    typedef enum logic [2:0] {
        PH_HEADER    = 3'd0,
        PH_FIXED     = 3'd1,
        PH_NAME      = 3'd2,
        PH_PAD       = 3'd3,
        PH_CHECKSUM  = 3'd4,
        PH_SIG       = 3'd5,
        PH_AFTER_SIG = 3'd6,
        PH_AFTER_SUM = 3'd7
    } phase_t;

    // Region codes reported with each byte
    localparam logic [2:0] RGN_HEADER    = 3'd0;
    localparam logic [2:0] RGN_FIXED     = 3'd1;
    localparam logic [2:0] RGN_NAME      = 3'd2;
    localparam logic [2:0] RGN_PAD       = 3'd3;
    localparam logic [2:0] RGN_CHECKSUM  = 3'd4;
    localparam logic [2:0] RGN_SIG       = 3'd5;
    localparam logic [2:0] RGN_EXT_UNK   = 3'd6;
    localparam logic [2:0] RGN_DONE      = 3'd7;

    // Field identifiers
    localparam logic [3:0] FID_ENTRY_BASE = 4'd3;
    localparam logic [3:0] FID_HASH       = 4'd13;
    localparam logic [3:0] FID_FLAGS      = 4'd14;
    localparam logic [3:0] FID_NONE       = 4'd15;

    // Extension kinds
    localparam logic [2:0] KIND_TREE      = 3'd0;
    localparam logic [2:0] KIND_LINK      = 3'd1;
    localparam logic [2:0] KIND_UNTR      = 3'd2;
    localparam logic [2:0] KIND_UNKNOWN   = 3'd3;
    localparam logic [2:0] KIND_UNDECIDED = 3'd4;

    // Section sizes
    localparam logic [5:0]  HDR_LAST_POS    = 6'd11;
    localparam logic [5:0]  WORDS_END_POS   = 6'd40;
    localparam logic [5:0]  HASH_END_POS    = 6'd60;
    localparam logic [5:0]  FIXED_LAST_POS  = 6'd61;
    localparam logic [5:0]  SUM_LAST_POS    = 6'd19;
    localparam logic [5:0]  SIG_LAST_POS    = 6'd3;
    localparam logic [16:0] CHECKSUM_BYTES  = 17'd20;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_file;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  region;
        logic [3:0]  field_id;
        logic        field_done;
        logic [31:0] field_value;
        logic [31:0] entry_number;
        logic [2:0]  extension_kind;
        logic [15:0] byte_offset;
    } out_item_t;

    typedef struct packed {
        phase_t      parse_phase;
        logic [5:0]  byte_in_section;
        logic [31:0] value_shift;
        logic [31:0] entries_total;
        logic [31:0] entry_counter;
        logic [15:0] file_offset;
        logic [2:0]  pad_remaining;
        logic [2:0]  signature_match;
    } parse_state_t;

    localparam parse_state_t STATE_CLEAR = '{
        parse_phase:     PH_HEADER,
        byte_in_section: 6'd0,
        value_shift:     32'd0,
        entries_total:   32'd0,
        entry_counter:   32'd0,
        file_offset:     16'd0,
        pad_remaining:   3'd0,
        signature_match: 3'b111
    };

    // Extension signature bytes: TREE, link, UNTR
    function automatic logic [7:0] sig_byte(input logic [1:0] kind, input logic [1:0] pos);
        logic [7:0] c;
        c = 8'h00;
        case (kind)
            2'd0: begin
                case (pos)
                    2'd0:    c = 8'h54;
                    2'd1:    c = 8'h52;
                    default: c = 8'h45;
                endcase
            end
            2'd1: begin
                case (pos)
                    2'd0:    c = 8'h6c;
                    2'd1:    c = 8'h69;
                    2'd2:    c = 8'h6e;
                    default: c = 8'h6b;
                endcase
            end
            default: begin
                case (pos)
                    2'd0:    c = 8'h55;
                    2'd1:    c = 8'h4e;
                    2'd2:    c = 8'h54;
                    default: c = 8'h52;
                endcase
            end
        endcase
        return c;
    endfunction

    // First surviving candidate wins
    function automatic logic [2:0] decided_kind(input logic [2:0] match);
        logic [2:0] k;
        if (match[0]) begin
            k = KIND_TREE;
        end else if (match[1]) begin
            k = KIND_LINK;
        end else if (match[2]) begin
            k = KIND_UNTR;
        end else begin
            k = KIND_UNKNOWN;
        end
        return k;
    endfunction

endpackage

>>> rtl/dircache_index_stream_parser.sv
// Latency: a result is valid the cycle after its byte transfer (one register stage).
// Throughput: one byte per cycle while m_ready is high; the result register refills in the cycle it drains.
// Reset: synchronous active-low aresetn clears parse state, total_length and the
// result valid; a byte with start_of_file set restarts parsing at offset zero.
module dircache_index_stream_parser import dcip_pkg::*; #(
    parameter longint unsigned MAX_FILE_BYTES = 65536
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data
);

    // last offset value, capped to the 16-bit offset field
    localparam longint unsigned LIMIT_FULL = MAX_FILE_BYTES - 1;
    localparam logic [15:0] OFFSET_LIMIT =
        (LIMIT_FULL > 64'd65535) ? 16'hFFFF : LIMIT_FULL[15:0];

    parse_state_t state_reg;
    parse_state_t state_next;
    out_item_t    result_next;
    out_item_t    result_reg;
    logic         valid_reg;
    logic [15:0]  total_length_reg;
    logic         in_xfer;

    assign s_ready = !valid_reg || m_ready;
    assign in_xfer = s_valid && s_ready;
    assign m_valid = valid_reg;
    assign m_data  = result_reg;

    dcip_step #(
        .OFFSET_LIMIT(OFFSET_LIMIT)
    ) u_step (
        .cur_state   (state_reg),
        .in_item     (s_data),
        .total_length(total_length_reg),
        .next_state  (state_next),
        .result      (result_next)
    );

    // length register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_length_reg <= 16'd0;
        end else if (cfg_wr_en) begin
            total_length_reg <= cfg_wr_data;
        end
    end

    // parse state advances on each input transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= STATE_CLEAR;
        end else if (in_xfer) begin
            state_reg <= state_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_xfer) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            result_reg <= result_next;
        end
    end

endmodule

>>> rtl/dcip_step.sv
module dcip_step import dcip_pkg::*; #(
    parameter logic [15:0] OFFSET_LIMIT = 16'hFFFF
) (
    input  parse_state_t cur_state,
    input  in_item_t     in_item,
    input  logic [15:0]  total_length,
    output parse_state_t next_state,
    output out_item_t    result
);

    always_comb begin
        parse_state_t st;
        parse_state_t ns;
        out_item_t    res;
        logic [15:0]  off_next;
        logic [5:0]   pos;
        logic [5:0]   pos_inc;
        logic [7:0]   b;
        logic [31:0]  word;
        logic [31:0]  cnt;
        logic [2:0]   match;
        logic         do_end;
        logic         do_trailer;

        st = in_item.start_of_file ? STATE_CLEAR : cur_state;
        ns = st;
        b = in_item.data_byte;
        pos = st.byte_in_section;
        pos_inc = pos + 6'd1;
        word = (pos[1:0] == 2'd0) ? {24'd0, b} : {st.value_shift[23:0], b};
        cnt = st.entry_counter + 32'd1;
        match = st.signature_match;
        do_end = 1'b0;
        do_trailer = 1'b0;

        // saturating file offset
        off_next = (st.file_offset >= OFFSET_LIMIT) ? st.file_offset : st.file_offset + 16'd1;
        ns.file_offset = off_next;

        res.region = RGN_HEADER;
        res.field_id = FID_NONE;
        res.field_done = 1'b0;
        res.field_value = 32'd0;
        res.extension_kind = KIND_UNDECIDED;
        res.byte_offset = st.file_offset;

        case (st.parse_phase)
            PH_HEADER: begin
                res.region = RGN_HEADER;
                res.field_id = pos[5:2];
                ns.value_shift = word;
                res.field_value = word;
                res.field_done = (pos[1:0] == 2'd3);
                if (pos >= HDR_LAST_POS) begin
                    ns.entries_total = word;
                    ns.entry_counter = 32'd0;
                    ns.byte_in_section = 6'd0;
                    if (word == 32'd0) begin
                        do_trailer = 1'b1;
                    end else begin
                        ns.parse_phase = PH_FIXED;
                    end
                end else begin
                    ns.byte_in_section = pos_inc;
                end
            end
            PH_FIXED: begin
                res.region = RGN_FIXED;
                if (pos < WORDS_END_POS) begin
                    res.field_id = FID_ENTRY_BASE + pos[5:2];
                    ns.value_shift = word;
                    res.field_value = word;
                    res.field_done = (pos[1:0] == 2'd3);
                end else if (pos < HASH_END_POS) begin
                    res.field_id = FID_HASH;
                end else begin
                    // 16-bit flags word
                    res.field_id = FID_FLAGS;
                    ns.value_shift = (pos == HASH_END_POS) ? {24'd0, b}
                                                           : {16'd0, st.value_shift[7:0], b};
                    res.field_value = ns.value_shift;
                    res.field_done = (pos == FIXED_LAST_POS);
                end
                ns.byte_in_section = pos_inc;
                if (pos >= FIXED_LAST_POS) begin
                    ns.parse_phase = PH_NAME;
                end
            end
            PH_NAME: begin
                if (b != 8'd0) begin
                    res.region = RGN_NAME;
                    ns.byte_in_section = pos_inc;
                end else begin
                    // terminator counts as padding
                    res.region = RGN_PAD;
                    ns.pad_remaining = 3'd0 - pos_inc[2:0];
                    if (ns.pad_remaining == 3'd0) begin
                        do_end = 1'b1;
                    end else begin
                        ns.parse_phase = PH_PAD;
                    end
                end
            end
            PH_PAD: begin
                res.region = RGN_PAD;
                ns.pad_remaining = st.pad_remaining - 3'd1;
                if (ns.pad_remaining == 3'd0) begin
                    do_end = 1'b1;
                end
            end
            PH_CHECKSUM: begin
                res.region = RGN_CHECKSUM;
                ns.byte_in_section = pos_inc;
                if (pos >= SUM_LAST_POS) begin
                    ns.parse_phase = PH_AFTER_SUM;
                end
            end
            PH_SIG: begin
                res.region = RGN_SIG;
                for (int k = 0; k < 3; k++) begin
                    if (sig_byte(2'(k), pos[1:0]) != b) begin
                        match[k] = 1'b0;
                    end
                end
                ns.signature_match = match;
                ns.byte_in_section = pos_inc;
                if (pos >= SIG_LAST_POS) begin
                    ns.parse_phase = PH_AFTER_SIG;
                    res.extension_kind = decided_kind(match);
                end
            end
            PH_AFTER_SIG: begin
                res.extension_kind = decided_kind(match);
                res.region = (res.extension_kind == KIND_UNKNOWN) ? RGN_EXT_UNK : RGN_DONE;
            end
            default: begin
                res.region = RGN_DONE;
            end
        endcase

        // end of one entry
        if (do_end) begin
            ns.entry_counter = cnt;
            ns.byte_in_section = 6'd0;
            if (cnt == ns.entries_total) begin
                do_trailer = 1'b1;
            end else begin
                ns.parse_phase = PH_FIXED;
            end
        end

        // trailer: checksum only when exactly its size is left
        if (do_trailer) begin
            ns.byte_in_section = 6'd0;
            ns.signature_match = 3'b111;
            if ({1'b0, off_next} + CHECKSUM_BYTES == {1'b0, total_length}) begin
                ns.parse_phase = PH_CHECKSUM;
            end else begin
                ns.parse_phase = PH_SIG;
            end
        end

        res.entry_number = ns.entry_counter;
        next_state = ns;
        result = res;
    end

endmodule
